>>> hw/rtl/kpq_pkg.sv
// Shared types and codes for the keyed priority task queue.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package kpq_pkg;

    // field widths
    localparam int OWNER_W = 16;
    localparam int TASK_W  = 16;
    localparam int PRIO_W  = 31;
    localparam int KEY_W   = PRIO_W + TASK_W;

    // commands
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_EDIT   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_EXEC   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // per-cycle operation broadcast to every cell
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_SHIFT = 2'd1;
    localparam logic [1:0] CELL_DEL   = 2'd2;
    localparam logic [1:0] CELL_INS   = 2'd3;

    // one stored task
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [TASK_W-1:0]  task_id;
        logic [PRIO_W-1:0]  prio;
    } kpq_data_t;

    // control broadcast from the sequencer to the chain
    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   ckey;
        logic [OWNER_W-1:0] ins_owner;
        logic               match_en;
        logic [TASK_W-1:0]  match_id;
    } kpq_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/kpq_cell.sv
// One cell of the sorted task chain: holds a single entry and moves it
// left, right or keeps it as the broadcast operation asks. Uses kpq_pkg.
`default_nettype none

module kpq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kpq_pkg::kpq_ctrl_t ctrl,
    input  wire logic              left_valid,
    input  wire kpq_pkg::kpq_data_t left_data,
    input  wire logic              left_keep,
    input  wire logic              right_valid,
    input  wire kpq_pkg::kpq_data_t right_data,
    output logic                   valid,
    output kpq_pkg::kpq_data_t     data,
    output logic                   keep,
    output logic                   match
);

    logic                            valid_reg;
    logic                            valid_next;
    kpq_pkg::kpq_data_t              data_reg;
    kpq_pkg::kpq_data_t              data_next;
    logic                            match_reg;
    logic                            match_next;
    logic [kpq_pkg::KEY_W-1:0]       own_key;
    kpq_pkg::kpq_data_t              ins_data;

    // entry stays in place when it ranks above the broadcast key
    assign own_key = {data_reg.prio, data_reg.task_id};
    assign keep    = valid_reg && (own_key > ctrl.ckey);

    assign ins_data.owner   = ctrl.ins_owner;
    assign ins_data.task_id = ctrl.ckey[kpq_pkg::TASK_W-1:0];
    assign ins_data.prio    = ctrl.ckey[kpq_pkg::KEY_W-1:kpq_pkg::TASK_W];

    // pick the next entry from self, left or right neighbor, or the new task
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctrl.op)
            kpq_pkg::CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            kpq_pkg::CELL_SHIFT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            kpq_pkg::CELL_DEL:
            begin
                if (!keep)
                begin
                    valid_next = right_valid;
                    data_next  = right_data;
                end
            end
            kpq_pkg::CELL_INS:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        data_next  = ins_data;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        data_next  = left_data;
                    end
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // capture the identifier match when a beat is taken
    assign match_next = ctrl.match_en ?
                        (valid_reg && (data_reg.task_id == ctrl.match_id)) : match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

>>> hw/rtl/kpq_select.sv
// One-hot select over the chain: reports whether any cell matched and
// returns the key and owner of the matching cell. Uses kpq_pkg.
`default_nettype none

module kpq_select #(
    parameter int CAPACITY = 64
) (
    input  wire logic [CAPACITY-1:0]      match,
    input  wire kpq_pkg::kpq_data_t       data [CAPACITY],
    output logic                          found,
    output logic [kpq_pkg::KEY_W-1:0]     key,
    output logic [kpq_pkg::OWNER_W-1:0]   owner
);

    // fold the masked entries; at most one match bit is set
    always_comb
    begin
        found = 1'b0;
        key   = '0;
        owner = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found = found | match[i];
            key   = key | ({kpq_pkg::KEY_W{match[i]}} & {data[i].prio, data[i].task_id});
            owner = owner | ({kpq_pkg::OWNER_W{match[i]}} & data[i].owner);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/keyed_priority_task_queue.sv
// Top level of the keyed priority task queue: sequencer, cell chain and
// match select. Uses kpq_pkg, kpq_cell and kpq_select.
//
// Usage: drive cmd, user_id, task_id and priority_req and raise start; the
// beat is taken at a rising edge with start high and busy low. Each beat
// gives exactly one result on status and owner, shown for one cycle with
// done high; the receiver must take it then, it cannot stall the block.
// Tasks sit in a chain of CAPACITY cells kept sorted by priority, then task
// identifier, highest first, with valid entries packed toward cell 0.
// Steps from the accept edge to the result, each a state held while busy:
//   execute top: pop (cell 0 is popped, the chain shifts one place)
//   not found, full: the identifier match fold only
//   remove, add of a new task: match fold, then one chain update
//   edit, add of an existing task: match fold, delete, insert
// A new beat may be taken in the cycle that done is shown.
// Reset clears every cell's valid bit at once: the queue starts empty and
// no clearing pass is needed.
`default_nettype none

module keyed_priority_task_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] user_id,
    input  wire logic [15:0] task_id,
    input  wire logic [30:0] priority_req,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      owner
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_DEL    = 3'd2;
    localparam logic [2:0] S_INS    = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    localparam logic [CAPACITY-1:0] ONE_V = CAPACITY'(1);

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [1:0]                      cmd_reg;
    logic [1:0]                      cmd_next;
    logic [15:0]                     user_reg;
    logic [15:0]                     user_next;
    logic [15:0]                     id_reg;
    logic [15:0]                     id_next;
    logic [30:0]                     prio_reg;
    logic [30:0]                     prio_next;
    logic [kpq_pkg::KEY_W-1:0]       xkey_reg;
    logic [kpq_pkg::KEY_W-1:0]       xkey_next;
    logic [15:0]                     ins_owner_reg;
    logic [15:0]                     ins_owner_next;
    logic                            done_reg;
    logic                            done_next;
    logic [1:0]                      status_reg;
    logic [1:0]                      status_next;
    logic [15:0]                     owner_reg;
    logic [15:0]                     owner_next;

    kpq_pkg::kpq_ctrl_t              ctrl;
    logic [CAPACITY-1:0]             valid_vec;
    logic [CAPACITY-1:0]             keep_vec;
    logic [CAPACITY-1:0]             match_vec;
    kpq_pkg::kpq_data_t              data_arr [CAPACITY];
    logic [CAPACITY-1:0]             lv_vec;
    logic [CAPACITY-1:0]             lk_vec;
    logic [CAPACITY-1:0]             rv_vec;
    kpq_pkg::kpq_data_t              ld_arr [CAPACITY];
    kpq_pkg::kpq_data_t              rd_arr [CAPACITY];
    logic                            sel_found;
    logic [kpq_pkg::KEY_W-1:0]       sel_key;
    logic [15:0]                     sel_owner;
    logic                            accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // wire each cell to its neighbors; the ends see empty stubs
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lv_vec[gi] = 1'b0;
                assign ld_arr[gi] = '0;
                assign lk_vec[gi] = 1'b1;
            end
            else
            begin : g_mid
                assign lv_vec[gi] = valid_vec[gi-1];
                assign ld_arr[gi] = data_arr[gi-1];
                assign lk_vec[gi] = keep_vec[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign rv_vec[gi] = 1'b0;
                assign rd_arr[gi] = '0;
            end
            else
            begin : g_inner
                assign rv_vec[gi] = valid_vec[gi+1];
                assign rd_arr[gi] = data_arr[gi+1];
            end

            kpq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_valid  (lv_vec[gi]),
                .left_data   (ld_arr[gi]),
                .left_keep   (lk_vec[gi]),
                .right_valid (rv_vec[gi]),
                .right_data  (rd_arr[gi]),
                .valid       (valid_vec[gi]),
                .data        (data_arr[gi]),
                .keep        (keep_vec[gi]),
                .match       (match_vec[gi])
            );
        end
    endgenerate

    kpq_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .match (match_vec),
        .data  (data_arr),
        .found (sel_found),
        .key   (sel_key),
        .owner (sel_owner)
    );

    // broadcast the chain operation for this cycle
    always_comb
    begin
        ctrl.match_en  = accept;
        ctrl.match_id  = task_id;
        ctrl.ins_owner = ins_owner_reg;
        ctrl.ckey      = (state_reg == S_DEL) ? xkey_reg : {prio_reg, id_reg};
        case (state_reg)
            S_POP:    ctrl.op = valid_vec[0] ? kpq_pkg::CELL_SHIFT : kpq_pkg::CELL_HOLD;
            S_DEL:    ctrl.op = kpq_pkg::CELL_DEL;
            S_INS:    ctrl.op = kpq_pkg::CELL_INS;
            default:  ctrl.op = kpq_pkg::CELL_HOLD;
        endcase
    end

    // sequence one command through fold, delete, insert or pop steps
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        user_next      = user_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        xkey_next      = xkey_reg;
        ins_owner_next = ins_owner_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        owner_next     = owner_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    user_next  = user_id;
                    id_next    = task_id;
                    prio_next  = priority_req;
                    state_next = (cmd == kpq_pkg::CMD_EXEC) ? S_POP : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                xkey_next      = sel_key;
                ins_owner_next = (cmd_reg == kpq_pkg::CMD_EDIT) ? sel_owner : user_reg;
                if (sel_found)
                begin
                    state_next = S_DEL;
                end
                else if (cmd_reg != kpq_pkg::CMD_ADD)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = kpq_pkg::ST_MISSING;
                    owner_next  = '0;
                end
                else if (valid_vec[CAPACITY-1])
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = kpq_pkg::ST_FULL;
                    owner_next  = '0;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_DEL:
            begin
                if (cmd_reg == kpq_pkg::CMD_REMOVE)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = kpq_pkg::ST_OK;
                    owner_next  = '0;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = kpq_pkg::ST_OK;
                owner_next  = '0;
            end
            S_POP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (valid_vec[0])
                begin
                    status_next = kpq_pkg::ST_OK;
                    owner_next  = data_arr[0].owner;
                end
                else
                begin
                    status_next = kpq_pkg::ST_EMPTY;
                    owner_next  = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        user_reg      <= user_next;
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        xkey_reg      <= xkey_next;
        ins_owner_reg <= ins_owner_next;
        status_reg    <= status_next;
        owner_reg     <= owner_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign owner  = owner_reg;

    // a result beat always closes a command that was in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result without a command in progress");

    // valid entries stay packed toward cell 0
    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (((valid_vec + ONE_V) & valid_vec) == '0))
        else $error("hole in the task chain");

    // popping an empty chain reports empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP && !valid_vec[0]) |=>
        (done_reg && status_reg == kpq_pkg::ST_EMPTY))
        else $error("pop of empty chain not reported");

    // owner is zero on every result but a successful pop
    a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != kpq_pkg::ST_OK) |-> (owner_reg == '0))
        else $error("owner set on a failed command");

endmodule

`default_nettype wire
